// ----- sv/det_pkg.sv -----
// ----------------------------------------------------------------------------
// det_pkg: directory entry table shared definitions
// Table depth, index widths, entry layout and status codes.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int ENTRIES = 32;                      // 2 .. 256
  localparam int IDX_W   = $clog2(ENTRIES);         // slot address width
  localparam int CNT_W   = $clog2(ENTRIES + 1);     // walk counter, holds ENTRIES

  localparam int NAME_W  = 64;
  localparam int INODE_W = 15;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [INODE_W-1:0] inode;
  } entry_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_INODE  = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

endpackage

// ----- sv/directory_entry_table.sv -----
// ----------------------------------------------------------------------------
// directory_entry_table: fixed-size directory entry table
// Insert by name/inode into the first free slot, remove by slot index with
// compaction of the later entries. One status transfer per request.
// ----------------------------------------------------------------------------
// The table holds ENTRIES slots of {64-bit name key, 15-bit inode} in one
// simple dual-port RAM with a registered read. A slot with inode zero is
// free. Per-slot valid flops, cleared by reset, make unwritten slots read as
// all zero, so no clearing pass is needed after reset. One request is worked
// at a time. The result becomes valid in the same cycle that the block is
// ready for the next request, and a sink stall holds the block in its done
// state for as long as it lasts.
// An insert walks every slot through the RAM read port (one slot per cycle),
// drains the read pipe and writes the first free slot, or reports the table
// full; it ends early when an equal name is found, and a negative inode is
// refused without a walk.
// A removal at slot k copies each later slot down one place, one per cycle,
// then clears the last slot; a bad index is refused without a walk.
// The result sits in an output register, so the next request may be taken
// while it waits for the sink.
module directory_entry_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // name_key[63:0], inode_number[79:64], slot_index[87:80]
  input  logic        in_tuser,   // func (0 insert, 1 remove)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[2:0], slot_used[10:3], zero[15:11]
);
  import det_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_SHIFT = 6'b001000,
    S_CLEAR = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Table storage and its per-slot written flags
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // RAM ports
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data_r;
  logic               rd_vld_r;
  entry_t             rd_entry;        // read data, zero if never written
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  // Control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;          // next slot to read
  logic               pend_r, pend_nxt;        // read data returns this cycle
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic               found_r, found_nxt;      // a free slot seen
  logic [IDX_W-1:0]   free_r, free_nxt;        // lowest free slot
  logic               out_vld_r, out_vld_nxt;

  // Request and result payload
  logic [NAME_W-1:0]  key_r, key_nxt;
  logic [INODE_W-1:0] inode_r, inode_nxt;
  status_t            stat_r, stat_nxt;
  logic [7:0]         slot_r, slot_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  // Request fields
  logic [NAME_W-1:0]  req_key;
  logic [15:0]        req_inode;
  logic [7:0]         req_idx;
  logic               in_xfer;
  logic               cnt_more;

  assign req_key   = in_tdata[63:0];
  assign req_inode = in_tdata[79:64];
  assign req_idx   = in_tdata[87:80];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign rd_entry = rd_vld_r ? rd_data_r : '0;
  assign cnt_more = (cnt_r < CNT_W'(ENTRIES));

  // RAM: registered read, one write per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    found_nxt    = found_r;
    free_nxt     = free_r;
    key_nxt      = key_r;
    inode_nxt    = inode_r;
    stat_nxt     = stat_r;
    slot_nxt     = slot_r;
    valid_nxt    = valid_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    rd_addr      = cnt_r[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = pend_idx_r - IDX_W'(1);
    wr_data      = rd_entry;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt   = req_key;
          inode_nxt = req_inode[INODE_W-1:0];
          slot_nxt  = '0;
          stat_nxt  = ST_OK;
          found_nxt = 1'b0;
          if (op_t'(in_tuser) == OP_INSERT) begin
            cnt_nxt = '0;
            if (req_inode[15]) begin
              stat_nxt  = ST_NO_INODE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if ({1'b0, req_idx} >= 9'(ENTRIES)) begin
            stat_nxt  = ST_BAD_INDEX;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt   = CNT_W'(req_idx) + CNT_W'(1);
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SCAN: begin
        // compare the slot read last cycle, issue the next read
        if (pend_r && (rd_entry.name == key_r)) begin
          stat_nxt  = ST_EXISTS;
          state_nxt = S_DONE;
        end else begin
          if (pend_r && !found_r && (rd_entry.inode == '0)) begin
            found_nxt = 1'b1;
            free_nxt  = pend_idx_r;
          end
          if (cnt_more) begin
            pend_nxt     = 1'b1;
            pend_idx_nxt = cnt_r[IDX_W-1:0];
            cnt_nxt      = cnt_r + CNT_W'(1);
          end else if (!pend_r) begin
            if (found_r) begin
              state_nxt = S_WRITE;
            end else begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_WRITE: begin
        wr_en            = 1'b1;
        wr_addr          = free_r;
        wr_data.name     = key_r;
        wr_data.inode    = inode_r;
        valid_nxt[free_r] = 1'b1;
        stat_nxt         = ST_OK;
        slot_nxt         = 8'(free_r);
        state_nxt        = S_DONE;
      end

      S_SHIFT: begin
        // slot read last cycle moves down one place
        if (pend_r) begin
          wr_en              = 1'b1;
          valid_nxt[wr_addr] = 1'b1;
        end
        if (cnt_more) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_CLEAR;
        end
      end

      S_CLEAR: begin
        wr_en                = 1'b1;
        wr_addr              = IDX_W'(ENTRIES - 1);
        wr_data              = '0;
        valid_nxt[ENTRIES-1] = 1'b0;
        stat_nxt             = ST_OK;
        state_nxt            = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {5'd0, slot_r, stat_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      found_r   <= 1'b0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      found_r   <= found_nxt;
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    free_r     <= free_nxt;
    key_r      <= key_nxt;
    inode_r    <= inode_nxt;
    stat_r     <= stat_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- tb/det_checker.sv -----
// ----------------------------------------------------------------------------
// det_checker: scoreboard for the directory entry table
// Mirrors the table contents from every request transfer, predicts the
// status transfer it should cause and compares each result in order.
// ----------------------------------------------------------------------------
module det_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,   // name_key[63:0], inode_number[79:64], slot_index[87:80]
  input  logic        in_tuser,   // func (0 insert, 1 remove)
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status[2:0], slot_used[10:3], zero[15:11]
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import det_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot;
  } reply_t;

  reply_t             reply_q[$];
  logic [NAME_W-1:0]  dir_names  [ENTRIES];
  logic [INODE_W-1:0] dir_inodes [ENTRIES];

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch at %0t ns: %s, expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  // Applies one request to the mirrored table and returns its reply.
  task automatic apply_directory_op(input op_t op, input logic [NAME_W-1:0] key,
                                    input logic [15:0] inode, input logic [7:0] idx,
                                    output reply_t r);
    int  free_slot;
    bit  hit;
    r.status  = ST_OK;
    r.slot    = '0;
    free_slot = -1;
    hit       = 1'b0;
    if (op == OP_INSERT) begin
      if (inode[15]) begin
        r.status = ST_NO_INODE;
      end else begin
        // free slots keep their old name, so they take part in the match
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_names[i] == key) hit = 1'b1;
          if (free_slot < 0 && dir_inodes[i] == '0) free_slot = i;
        end
        if (hit) begin
          r.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          dir_names[free_slot]  = key;
          dir_inodes[free_slot] = inode[INODE_W-1:0];
          r.slot                = 8'(free_slot);
        end
      end
    end else if (int'(idx) >= ENTRIES) begin
      r.status = ST_BAD_INDEX;
    end else begin
      for (int i = int'(idx) + 1; i < ENTRIES; i++) begin
        dir_names[i-1]  = dir_names[i];
        dir_inodes[i-1] = dir_inodes[i];
      end
      dir_names[ENTRIES-1]  = '0;
      dir_inodes[ENTRIES-1] = '0;
    end
  endtask

  always @(posedge clk) begin : monitor
    reply_t exp_r;
    reply_t new_r;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        dir_names[i]  = '0;
        dir_inodes[i] = '0;
      end
      reply_q.delete();
    end else begin
      // result first: a request taken at this edge cannot answer at this edge
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding", -1,
                          int'(out_tdata[2:0]));
        end else begin
          exp_r = reply_q.pop_front();
          if (out_tdata[2:0] !== exp_r.status)
            report_mismatch("field status", int'(exp_r.status), int'(out_tdata[2:0]));
          if (out_tdata[10:3] !== exp_r.slot)
            report_mismatch("field slot_used", int'(exp_r.slot), int'(out_tdata[10:3]));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_directory_op(op_t'(in_tuser), in_tdata[63:0], in_tdata[79:64],
                           in_tdata[87:80], new_r);
        reply_q.push_back(new_r);
      end
    end
    pending = reply_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: directory entry table testbench
// Directed inserts and removals on the edges of every field, then phases of
// insert-heavy and remove-heavy random traffic over a small name pool so the
// table fills, collides and compacts. Checking lives in det_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import det_pkg::*;

  localparam int POOL_N     = 48;     // more names than slots, so the table can fill
  localparam int RAND_ITEMS = 1250;
  localparam int IDLE_PCT   = 26;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata   = '0;   // name_key[63:0], inode_number[79:64], slot_index[87:80]
  logic        in_tuser   = 1'b0; // func (0 insert, 1 remove)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // status[2:0], slot_used[10:3], zero[15:11]

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;       // set during the stretch with no idling on either side

  logic [63:0] name_pool [POOL_N];

  directory_entry_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  det_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side backpressure: one decision per cycle, at the falling edge.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // One request transfer. Called at a falling edge, returns at a falling edge,
  // so valid is assigned at most once per time step.
  task automatic send_request(input op_t op, input logic [63:0] key,
                              input logic [15:0] inode, input logic [7:0] idx);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {idx, inode, key};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    op_t         op;
    logic [63:0] key;
    logic [15:0] inode;
    logic [7:0]  idx;
    int          pick;
    bit          insert_heavy;

    for (int i = 0; i < POOL_N; i++)
      name_pool[i] = {$urandom, $urandom} | 64'h1;   // never the empty name

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed ----
    // empty name collides with the cleared names of a fresh table
    send_request(OP_INSERT, 64'h0, 16'd5, 8'd0);
    // all-ones name, largest inode: lands in slot 0
    send_request(OP_INSERT, '1, 16'h7FFF, 8'hFF);
    // same name again, refused
    send_request(OP_INSERT, '1, 16'd1, 8'd0);
    // most negative and minus one: no inode, ahead of the name check
    send_request(OP_INSERT, '1, 16'h8000, 8'd0);
    send_request(OP_INSERT, 64'h2, 16'hFFFF, 8'd0);
    // inode zero writes the name but leaves the slot free ...
    send_request(OP_INSERT, 64'h3, 16'd0, 8'd0);
    // ... so the next insert reuses it, and the old name is gone
    send_request(OP_INSERT, 64'h4, 16'd7, 8'd0);
    send_request(OP_INSERT, 64'h3, 16'd9, 8'd0);
    send_request(OP_INSERT, name_pool[0], 16'd11, 8'd0);
    // bad index: top of the range and just past the last slot
    send_request(OP_REMOVE, '1, 16'hFFFF, 8'hFF);
    send_request(OP_REMOVE, 64'h0, 16'd0, 8'(ENTRIES));
    // last slot, then slot 0 with compaction of the rest
    send_request(OP_REMOVE, 64'h0, 16'd0, 8'(ENTRIES - 1));
    send_request(OP_REMOVE, 64'h0, 16'd0, 8'd0);
    send_request(OP_REMOVE, '1, 16'h7FFF, 8'd1);
    // removed names can come back
    send_request(OP_INSERT, '1, 16'h1234, 8'd0);

    // ---- random ----
    // Phases of 100 alternate between filling (table full, name collisions)
    // and draining (compaction from every position). Unused fields carry noise.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm         = (n >= 500 && n < 750);
      insert_heavy = ((n / 100) % 2) == 0;
      pick         = $urandom_range(0, 99);
      op           = (pick < (insert_heavy ? 80 : 35)) ? OP_INSERT : OP_REMOVE;

      pick = $urandom_range(0, 99);
      if (pick < 70)      key = name_pool[$urandom_range(0, POOL_N - 1)];
      else if (pick < 95) key = {$urandom, $urandom};
      else                key = 64'h0;

      pick = $urandom_range(0, 99);
      if (pick < 10)      inode = 16'h8000 | 16'($urandom);
      else if (pick < 15) inode = 16'h0;
      else if (pick < 20) inode = 16'h7FFF;
      else                inode = 16'($urandom_range(1, 32767));

      pick = $urandom_range(0, 99);
      if (pick < 80)      idx = 8'($urandom_range(0, ENTRIES - 1));
      else if (pick < 90) idx = 8'($urandom_range(ENTRIES, 255));
      else                idx = 8'($urandom);

      send_request(op, key, inode, idx);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // drain, then give the block a full walk to show any stray result
    wait (pending == 0);
    repeat (ENTRIES + 10) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
